// File: src/rdbm_pkg.sv
// Shared types and constants for the round display band margin unit.
package rdbm_pkg;

	localparam int CoordW = 14;              // unsigned Q.4 coordinate width
	localparam int InW    = 15;              // signed Q.4 input width
	localparam int RootW  = CoordW;          // square root result width
	localparam int RadW   = 2 * RootW;       // radicand width
	localparam int RemW   = RootW + 1;       // partial remainder width
	localparam int AddrW  = 4;
	localparam int DataW  = 32;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_CENTER_X = 2'd0;
	localparam reg_idx_t REG_CENTER_Y = 2'd1;
	localparam reg_idx_t REG_RADIUS   = 2'd2;
	localparam reg_idx_t REG_SLACK    = 2'd3;

	// data that rides alongside the square root
	typedef struct packed {
		logic [CoordW-1:0] bcx;
		logic [CoordW-1:0] dx;
	} side_t;

	// word travelling from one root cell to the next
	typedef struct packed {
		logic            vld;
		logic [RadW-1:0] rad;
		logic [RootW-1:0] root;
		logic [RemW-1:0] rem;
		side_t           side;
	} cell_word_t;

endpackage

// File: src/rdbm_cell.sv
// One square root cell: resolves one root bit from two radicand bits per cycle.
module rdbm_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  rdbm_pkg::cell_word_t din,
	output rdbm_pkg::cell_word_t dout
);
	import rdbm_pkg::*;

	logic [RemW+1:0] rem_ext;
	logic [RemW+1:0] trial;
	logic [RemW+1:0] diff;
	logic            ge;

	logic             vld_q;
	logic [RadW-1:0]  rad_q;
	logic [RootW-1:0] root_q;
	logic [RemW-1:0]  rem_q;
	side_t            side_q;

	always_comb begin
		rem_ext = {din.rem, din.rad[RadW-1 -: 2]};
		trial   = {1'b0, din.root, 2'b01};
		diff    = rem_ext - trial;
		ge      = (rem_ext >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		rad_q  <= {din.rad[RadW-3:0], 2'b00};
		root_q <= {din.root[RootW-2:0], ge};
		rem_q  <= ge ? diff[RemW-1:0] : rem_ext[RemW-1:0];
		side_q <= din.side;
	end

	assign dout = {vld_q, rad_q, root_q, rem_q, side_q};

endmodule

// File: src/rdbm_root_chain.sv
// Row of root cells computing floor(sqrt) of the chord radicand, one bit per cell.
module rdbm_root_chain (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     vld,
	input  logic [rdbm_pkg::RadW-1:0] rad,
	input  rdbm_pkg::side_t          side,
	output logic                     root_vld,
	output logic [rdbm_pkg::RootW-1:0] root,
	output rdbm_pkg::side_t          root_side
);
	import rdbm_pkg::*;

	cell_word_t link [0:RootW];

	always_comb begin
		link[0].vld  = vld;
		link[0].rad  = rad;
		link[0].root = '0;
		link[0].rem  = '0;
		link[0].side = side;
	end

	for (genvar i = 0; i < RootW; i++) begin : g_cell
		rdbm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (link[i]),
			.dout   (link[i+1])
		);
	end

	assign root_vld  = link[RootW].vld;
	assign root      = link[RootW].root;
	assign root_side = link[RootW].side;

endmodule

// File: src/round_display_band_margin_unit.sv
// Top level: band margin on a round display, config registers and pipeline.
// Pipeline from start to done: 3 front stages, 14 root cells, 2 back stages.
// Throughput: one band per cycle; busy stays low, so start is taken on every cycle.
// The 14-cell root chain sets the depth; each cell resolves one root bit.
// Reset clears the config registers to zero and drops every word in flight.
// done pulses for one cycle with left_margin; the receiver cannot stall.
module round_display_band_margin_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rdbm_pkg::AddrW-1:0] paddr,
	input  logic [rdbm_pkg::DataW-1:0] pwdata,
	output logic [rdbm_pkg::DataW-1:0] prdata,
	output logic                       pready,
	input  logic                       start,
	output logic                       busy,
	input  logic [rdbm_pkg::InW-1:0]   band_top,
	input  logic [rdbm_pkg::InW-1:0]   band_height,
	input  logic [rdbm_pkg::CoordW-1:0] band_center_x,
	output logic                       done,
	output logic [rdbm_pkg::CoordW-1:0] left_margin
);
	import rdbm_pkg::*;

	logic [CoordW-1:0] cx_q, cy_q, radius_q, slack_q;
	reg_idx_t          idx;
	logic              wr_en;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			radius_q <= '0;
			slack_q  <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_CENTER_X: cx_q     <= pwdata[CoordW-1:0];
				REG_CENTER_Y: cy_q     <= pwdata[CoordW-1:0];
				REG_RADIUS:   radius_q <= pwdata[CoordW-1:0];
				REG_SLACK:    slack_q  <= pwdata[CoordW-1:0];
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_CENTER_X: prdata[CoordW-1:0] = cx_q;
			REG_CENTER_Y: prdata[CoordW-1:0] = cy_q;
			REG_RADIUS:   prdata[CoordW-1:0] = radius_q;
			REG_SLACK:    prdata[CoordW-1:0] = slack_q;
		endcase
	end

	// Stage 1: edge offsets and horizontal offset magnitudes
	logic              vld_s1;
	logic [15:0]       a_top_s1, a_bot_s1;
	side_t             side_s1;
	logic [16:0]       d_top, d_bot;
	logic [14:0]       d_x;
	logic              accept;

	assign accept = start && !busy;

	always_comb begin
		d_top = {{2{band_top[InW-1]}}, band_top} - {3'b000, cy_q};
		d_bot = {{2{band_top[InW-1]}}, band_top} + {{2{band_height[InW-1]}}, band_height}
			- {3'b000, cy_q};
		d_x   = {1'b0, cx_q} - {1'b0, band_center_x};
	end

	always_ff @(posedge clk) begin
		a_top_s1    <= d_top[16] ? 16'(-d_top) : d_top[15:0];
		a_bot_s1    <= d_bot[16] ? 16'(-d_bot) : d_bot[15:0];
		side_s1.dx  <= d_x[14] ? 14'(-d_x) : d_x[13:0];
		side_s1.bcx <= band_center_x;
	end

	// Stage 2: far edge, then r - far and r + far (zero outside the circle)
	logic              vld_s2;
	logic [CoordW-1:0] dif_s2;
	logic [CoordW:0]   sum_s2;
	side_t             side_s2;
	logic [15:0]       far;
	logic              in_circle;

	always_comb begin
		far       = (a_top_s1 > a_bot_s1) ? a_top_s1 : a_bot_s1;
		in_circle = far < {2'b00, radius_q};
	end

	always_ff @(posedge clk) begin
		dif_s2  <= in_circle ? (radius_q - far[CoordW-1:0]) : '0;
		sum_s2  <= {1'b0, radius_q} + {1'b0, far[CoordW-1:0]};
		side_s2 <= side_s1;
	end

	// Stage 3: r^2 - far^2 as (r - far) * (r + far)
	logic              vld_s3;
	logic [RadW-1:0]   rad_s3;
	side_t             side_s3;
	logic [RadW:0]     prod;

	assign prod = (RadW+1)'(dif_s2) * (RadW+1)'(sum_s2);

	always_ff @(posedge clk) begin
		rad_s3  <= prod[RadW-1:0];
		side_s3 <= side_s2;
	end

	logic              root_vld;
	logic [RootW-1:0]  root;
	side_t             root_side;

	rdbm_root_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld       (vld_s3),
		.rad       (rad_s3),
		.side      (side_s3),
		.root_vld  (root_vld),
		.root      (root),
		.root_side (root_side)
	);

	// Stage 18: usable half-width, clamped at zero
	logic              vld_s18;
	logic [CoordW-1:0] half_s18, bcx_s18;
	logic [16:0]       usable;

	assign usable = {3'b000, root} - {3'b000, slack_q} - {3'b000, root_side.dx};

	always_ff @(posedge clk) begin
		half_s18 <= usable[16] ? '0 : usable[CoordW-1:0];
		bcx_s18  <= root_side.bcx;
	end

	// Stage 19: margin, clamped at zero
	logic              vld_s19;
	logic [CoordW-1:0] margin_s19;
	logic [CoordW:0]   m;

	assign m = {1'b0, bcx_s18} - {1'b0, half_s18};

	always_ff @(posedge clk) begin
		margin_s19 <= m[CoordW] ? '0 : m[CoordW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s18 <= 1'b0;
			vld_s19 <= 1'b0;
		end else begin
			vld_s1  <= accept;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s18 <= root_vld;
			vld_s19 <= vld_s18;
		end
	end

	assign done        = vld_s19;
	assign left_margin = margin_s19;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the round display band margin unit.
`timescale 1ns / 100ps

module testbench;
	import rdbm_pkg::*;

	localparam int PipeDepth  = 19;
	localparam int PhaseBands = 175;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [AddrW-1:0]    paddr;
	logic [DataW-1:0]    pwdata;
	logic [DataW-1:0]    prdata;
	logic                pready;
	logic                start;
	logic                busy;
	logic [InW-1:0]      band_top;
	logic [InW-1:0]      band_height;
	logic [CoordW-1:0]   band_center_x;
	logic                done;
	logic [CoordW-1:0]   left_margin;

	// shadow copy of the register file
	logic [CoordW-1:0]   cfg_cx;
	logic [CoordW-1:0]   cfg_cy;
	logic [CoordW-1:0]   cfg_radius;
	logic [CoordW-1:0]   cfg_slack;

	logic [CoordW-1:0]   margin_q[$];
	logic [CoordW-1:0]   margin_exp;
	int                  fail_count;
	int                  bands_sent;
	int                  margins_seen;
	int                  settings_done;
	bit                  gaps_on;

	round_display_band_margin_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.start         (start),
		.busy          (busy),
		.band_top      (band_top),
		.band_height   (band_height),
		.band_center_x (band_center_x),
		.done          (done),
		.left_margin   (left_margin)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("round_display_band_margin_unit verification failed");
		$finish;
	end

	// floor of the square root, one root bit per trial
	function automatic longint root_floor(input longint radicand);
		longint root;
		longint trial;
		root = 0;
		for (int b = CoordW; b >= 0; b--) begin
			trial = root | (longint'(1) << b);
			if (trial * trial <= radicand)
				root = trial;
		end
		return root;
	endfunction

	function automatic logic [CoordW-1:0] predict_margin(input logic [InW-1:0] top,
			input logic [InW-1:0] height, input logic [CoordW-1:0] bcx);
		longint t;
		longint d_top;
		longint d_bot;
		longint far;
		longint r;
		longint dx;
		longint half;
		longint margin;
		t = longint'($signed(top));
		d_top = t - longint'(cfg_cy);
		d_bot = t + longint'($signed(height)) - longint'(cfg_cy);
		if (d_top < 0) d_top = -d_top;
		if (d_bot < 0) d_bot = -d_bot;
		far = (d_top > d_bot) ? d_top : d_bot;
		r = longint'(cfg_radius);
		dx = longint'(cfg_cx) - longint'(bcx);
		if (dx < 0) dx = -dx;
		half = (far >= r) ? 0 : root_floor(r * r - far * far);
		half = half - longint'(cfg_slack) - dx;
		if (half < 0) half = 0;
		margin = longint'(bcx) - half;
		if (margin < 0) margin = 0;
		return margin[CoordW-1:0];
	endfunction

	// compare each margin word against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			margins_seen++;
			if (margin_q.size() == 0) begin
				$error("left_margin expected none got %0d", left_margin);
				fail_count++;
			end else begin
				margin_exp = margin_q.pop_front();
				if (left_margin !== margin_exp) begin
					$error("left_margin expected %0d got %0d", margin_exp, left_margin);
					fail_count++;
				end
			end
		end
	end

	task automatic send_band(input logic [InW-1:0] top, input logic [InW-1:0] height,
			input logic [CoordW-1:0] bcx);
		while (gaps_on && $urandom_range(0, 99) < 25) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start         <= 1'b1;
		band_top      <= top;
		band_height   <= height;
		band_center_x <= bcx;
		do @(posedge clk); while (busy);
		margin_q.push_back(predict_margin(top, height, bcx));
		bands_sent++;
	endtask

	// hold off until every predicted margin has come back
	task automatic drain_pipe;
		start <= 1'b0;
		while (margin_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CoordW-1:0] val);
		logic [DataW-1:0] word;
		word = $urandom();
		word[CoordW-1:0] = val;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_CENTER_X: cfg_cx = val;
			REG_CENTER_Y: cfg_cy = val;
			REG_RADIUS:   cfg_radius = val;
			REG_SLACK:    cfg_slack = val;
		endcase
	endtask

	task automatic check_reg(input reg_idx_t idx, input logic [CoordW-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== DataW'(val)) begin
			$error("prdata expected %0d got %0d", val, prdata);
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_circle(input logic [CoordW-1:0] cx, input logic [CoordW-1:0] cy,
			input logic [CoordW-1:0] r, input logic [CoordW-1:0] slack);
		drain_pipe();
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_RADIUS, r);
		write_reg(REG_SLACK, slack);
		check_reg(REG_CENTER_X, cx);
		check_reg(REG_CENTER_Y, cy);
		check_reg(REG_RADIUS, r);
		check_reg(REG_SLACK, slack);
		settings_done++;
	endtask

	// mostly bands that cross the circle, the rest raw noise
	task automatic send_random_band;
		int r;
		int hr;
		int top;
		int height;
		int bcx;
		r = int'(cfg_radius);
		if ($urandom_range(0, 9) < 7) begin
			hr = r / 4 + 1;
			top = int'(cfg_cy) - r + int'($urandom_range(0, 2 * r));
			height = int'($urandom_range(0, 2 * hr)) - hr;
			bcx = int'(cfg_cx) - r + int'($urandom_range(0, 2 * r));
			if (bcx < 0) bcx = 0;
			if (bcx > 16383) bcx = 16383;
			send_band(top[InW-1:0], height[InW-1:0], bcx[CoordW-1:0]);
		end else begin
			send_band(InW'($urandom()), InW'($urandom()), CoordW'($urandom()));
		end
	endtask

	task automatic test_reset_defaults;
		check_reg(REG_CENTER_X, '0);
		check_reg(REG_CENTER_Y, '0);
		check_reg(REG_RADIUS, '0);
		check_reg(REG_SLACK, '0);
		send_band(0, 0, 0);
		send_band(-16384, 16383, 16383);
		send_band(16383, -16384, 8191);
	endtask

	task automatic test_band_geometry;
		load_circle(8000, 8000, 4000, 16);
		send_band(7990, 20, 8000);
		send_band(12000, 0, 8000);      // edge exactly on the circle
		send_band(11999, 0, 8000);
		send_band(-16384, 0, 8000);     // far outside
		send_band(7950, 100, 8000);     // equal edge magnitudes
		send_band(8100, -300, 7900);    // bottom row above top row
		send_band(8000, 0, 16383);      // offset exceeds the chord
		send_band(16383, 16383, 0);
		send_band(-16384, -16384, 100);
	endtask

	task automatic test_config_extremes;
		load_circle(0, 0, 16383, 0);
		send_band(0, 0, 16383);
		send_band(0, 0, 0);             // half-width beyond band centre
		send_band(0, 0, 100);
		send_band(-16384, -16384, 5000);
		load_circle(16383, 16383, 16383, 16383);
		send_band(16383, 0, 16383);     // slack swallows the chord
		send_band(16383, -16384, 12000);
		send_band(0, 16383, 0);
	endtask

	task automatic test_random_bands;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: load_circle(CoordW'($urandom_range(4000, 12000)),
						CoordW'($urandom_range(4000, 12000)),
						CoordW'($urandom_range(1000, 4000)), CoordW'($urandom_range(0, 64)));
				1: load_circle(16383, 16383, 16383, 0);
				2: load_circle(0, 0, 16383, 16383);
				3: load_circle(CoordW'($urandom()), CoordW'($urandom()),
						CoordW'($urandom()), CoordW'($urandom()));
				4: load_circle(CoordW'($urandom()), CoordW'($urandom()),
						CoordW'($urandom_range(1, 64)), CoordW'($urandom_range(0, 8)));
				default: load_circle(CoordW'($urandom_range(0, 16383)),
						CoordW'($urandom_range(0, 16383)),
						CoordW'($urandom_range(0, 16383)), CoordW'($urandom_range(0, 256)));
			endcase
			gaps_on = (phase != 3);
			for (int i = 0; i < PhaseBands; i++)
				send_random_band();
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		start         <= 1'b0;
		band_top      <= '0;
		band_height   <= '0;
		band_center_x <= '0;
		cfg_cx        = '0;
		cfg_cy        = '0;
		cfg_radius    = '0;
		cfg_slack     = '0;
		fail_count    = 0;
		bands_sent    = 0;
		margins_seen  = 0;
		settings_done = 0;
		gaps_on       = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_band_geometry();
		test_config_extremes();
		test_random_bands();

		drain_pipe();
		repeat (PipeDepth + 10) @(posedge clk);
		$display("bands sent %0d, margins checked %0d, circle settings %0d",
				bands_sent, margins_seen, settings_done);
		$display("covered reset defaults, edge and clamp cases, extreme and random circles");
		if (fail_count == 0) begin
			$display("round_display_band_margin_unit verification clean");
		end else begin
			$display("round_display_band_margin_unit verification failed");
		end
		$finish;
	end

endmodule
